// File: rtl/core/fpa_pkg.sv
`timescale 1ns / 1ps

package fpa_pkg;

   localparam int BLOCK_W     = 10;
   localparam int COUNT_W     = 11;
   localparam int ADDR_W      = 18;
   localparam int OP_W        = 2;
   localparam int CFG_INDEX_W = 1;
   localparam int CFG_DATA_W  = 5;

   typedef logic [OP_W-1:0]        op_type;
   typedef logic [BLOCK_W-1:0]     block_type;
   typedef logic [CFG_INDEX_W-1:0] cfg_index_type;

   localparam op_type OP_REGISTER      = 2'd0;
   localparam op_type OP_ALLOC         = 2'd1;
   localparam op_type OP_FREE_EMPTY    = 2'd2;
   localparam op_type OP_FREE_RESERVED = 2'd3;

   localparam cfg_index_type CFG_RELOCATE_MODE   = 1'd0;
   localparam cfg_index_type CFG_RESERVED_TARGET = 1'd1;

   localparam logic [CFG_DATA_W-1:0] RESERVED_TARGET_RESET = 5'd1;

endpackage

// File: rtl/core/flash_page_allocator.sv
`timescale 1ns / 1ps

// channel  direction  tdata (low bit up)                              tuser
// req_     in         block_index[9:0], zero pad to 16                operation[1:0], bad_block
// rsp_     out        page_address[17:0], empty_count, reserved_count error
// csr_     in         write enable, register index, data (5 bits)     -
//
// each request is taken in while the queue head is read from the block ram,
// then pointers are updated, the ram written and the result loaded
// a new request is taken at the earliest on the edge that takes the waiting result
// reset is synchronous and clears pointers, counts and the open block
// the block ram needs no clearing, only written entries are ever used

module flash_page_allocator
   import fpa_pkg::*;
#(
   parameter int NUM_BLOCKS      = 1024,
   parameter int PAGES_PER_BLOCK = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,  // block_index
   input  logic [2:0]            req_tuser,  // operation, bad_block
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,  // page_address, empty_count, reserved_count
   output logic                  rsp_tuser,  // error
   input  logic                  csr_we,
   input  cfg_index_type         csr_index,
   input  logic [CFG_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
   localparam int OFF_W   = $clog2(PAGES_PER_BLOCK + 1);
   localparam int CALC_W  = BLOCK_W + OFF_W;
   localparam int AW      = (CALC_W > ADDR_W) ? CALC_W : ADDR_W;
   localparam int TW      = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

   logic                  busy_ff, busy_in;
   op_type                op_ff;
   block_type             blk_ff;
   logic                  bad_ff;
   logic                  relocate_mode_ff;
   logic [CFG_DATA_W-1:0] reserved_target_ff;
   logic [PTR_W-1:0]      empty_head_ff, empty_head_in;
   logic [PTR_W-1:0]      empty_tail_ff, empty_tail_in;
   logic [CNT_W-1:0]      empty_used_ff, empty_used_in;
   logic [CNT_W-1:0]      reserved_used_ff, reserved_used_in;
   block_type             open_block_ff, open_block_in;
   logic                  open_valid_ff, open_valid_in;
   logic [OFF_W-1:0]      page_offset_ff, page_offset_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic                  rsp_err_ff, rsp_err_in;
   logic [COUNT_W-1:0]    rsp_empty_ff, rsp_empty_in;
   logic [COUNT_W-1:0]    rsp_res_ff, rsp_res_in;

   logic                  req_take;
   logic                  push_empty, push_res, pop_empty;
   logic                  empty_full, res_full, empty_nz, need_open;
   block_type             head_blk, addr_blk;
   logic [OFF_W-1:0]      addr_off;
   logic [AW-1:0]         addr_wide;

   assign req_tready = !busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_take   = req_tvalid && req_tready;

   fpa_block_ram #(
      .DEPTH (NUM_BLOCKS)
   ) u_empty_ram (
      .clock   (clock),
      .wr_en   (push_empty),
      .wr_addr (empty_tail_ff),
      .wr_data (blk_ff),
      .rd_addr (empty_head_ff),
      .rd_data (head_blk)
   );

   assign empty_full = (empty_used_ff == CNT_W'(NUM_BLOCKS));
   assign res_full   = (reserved_used_ff == CNT_W'(NUM_BLOCKS));
   assign empty_nz   = (empty_used_ff != '0);
   assign need_open  = !open_valid_ff || (page_offset_ff >= OFF_W'(PAGES_PER_BLOCK));

   always_comb begin
      push_empty     = 1'b0;
      push_res       = 1'b0;
      pop_empty      = 1'b0;
      rsp_err_in     = 1'b0;
      open_block_in  = open_block_ff;
      open_valid_in  = open_valid_ff;
      page_offset_in = page_offset_ff;
      addr_blk       = open_block_ff;
      addr_off       = page_offset_ff;
      if (busy_ff) begin
         case (op_ff)
            OP_REGISTER: begin
               if (!bad_ff) begin
                  if (TW'(reserved_used_ff) < TW'(reserved_target_ff)) begin
                     push_res = !res_full;
                  end else begin
                     push_empty = !empty_full;
                  end
               end
            end
            OP_ALLOC: begin
               if (need_open) begin
                  if (!empty_nz) begin
                     rsp_err_in = 1'b1;
                  end else begin
                     pop_empty      = 1'b1;
                     open_block_in  = head_blk;
                     open_valid_in  = 1'b1;
                     page_offset_in = OFF_W'(1);
                     addr_blk       = head_blk;
                     addr_off       = '0;
                  end
               end else if (relocate_mode_ff && empty_nz) begin
                  pop_empty      = 1'b1;
                  open_block_in  = head_blk;
                  page_offset_in = page_offset_ff + OFF_W'(1);
                  addr_blk       = head_blk;
               end else begin
                  page_offset_in = page_offset_ff + OFF_W'(1);
               end
            end
            OP_FREE_EMPTY: begin
               push_empty = !empty_full;
            end
            OP_FREE_RESERVED: begin
               push_res = !res_full;
            end
            default: begin
               push_empty = 1'b0;
            end
         endcase
      end
   end

   assign addr_wide = AW'(addr_blk) * AW'(PAGES_PER_BLOCK) + AW'(addr_off);

   always_comb begin
      empty_head_in    = empty_head_ff;
      empty_tail_in    = empty_tail_ff;
      empty_used_in    = empty_used_ff;
      reserved_used_in = reserved_used_ff;
      if (pop_empty) begin
         empty_head_in = (empty_head_ff == PTR_W'(NUM_BLOCKS - 1)) ? '0
                                                                   : empty_head_ff + PTR_W'(1);
         empty_used_in = empty_used_ff - CNT_W'(1);
      end
      if (push_empty) begin
         empty_tail_in = (empty_tail_ff == PTR_W'(NUM_BLOCKS - 1)) ? '0
                                                                   : empty_tail_ff + PTR_W'(1);
         empty_used_in = empty_used_ff + CNT_W'(1);
      end
      if (push_res) begin
         reserved_used_in = reserved_used_ff + CNT_W'(1);
      end
   end

   always_comb begin
      busy_in      = busy_ff ? 1'b0 : req_take;
      rsp_valid_in = busy_ff ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      rsp_addr_in  = (op_ff == OP_ALLOC && !rsp_err_in) ? addr_wide[ADDR_W-1:0] : '0;
      rsp_empty_in = COUNT_W'(empty_used_in);
      rsp_res_in   = COUNT_W'(reserved_used_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff            <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         relocate_mode_ff   <= 1'b0;
         reserved_target_ff <= RESERVED_TARGET_RESET;
         empty_head_ff      <= '0;
         empty_tail_ff      <= '0;
         empty_used_ff      <= '0;
         reserved_used_ff   <= '0;
         open_block_ff      <= '0;
         open_valid_ff      <= 1'b0;
         page_offset_ff     <= '0;
      end else begin
         busy_ff          <= busy_in;
         rsp_valid_ff     <= rsp_valid_in;
         empty_head_ff    <= empty_head_in;
         empty_tail_ff    <= empty_tail_in;
         empty_used_ff    <= empty_used_in;
         reserved_used_ff <= reserved_used_in;
         open_block_ff    <= open_block_in;
         open_valid_ff    <= open_valid_in;
         page_offset_ff   <= page_offset_in;
         if (csr_we) begin
            case (csr_index)
               CFG_RELOCATE_MODE:   relocate_mode_ff   <= csr_wdata[0];
               CFG_RESERVED_TARGET: reserved_target_ff <= csr_wdata;
               default:             relocate_mode_ff   <= relocate_mode_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_tuser[OP_W-1:0];
         bad_ff <= req_tuser[OP_W];
         blk_ff <= req_tdata[BLOCK_W-1:0];
      end
      if (busy_ff) begin
         rsp_addr_ff  <= rsp_addr_in;
         rsp_err_ff   <= rsp_err_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_res_ff   <= rsp_res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_res_ff, rsp_empty_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

// File: rtl/core/fpa_block_ram.sv
`timescale 1ns / 1ps

module fpa_block_ram
   import fpa_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PTR_W-1:0] wr_addr,
   input  block_type        wr_data,
   input  logic [PTR_W-1:0] rd_addr,
   output block_type        rd_data
);

   block_type mem_ff [DEPTH];
   block_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/sv/fpa_checker.sv
`timescale 1ns / 1ps

module fpa_checker
   import fpa_pkg::*;
#(
   parameter int NUM_BLOCKS      = 1024,
   parameter int PAGES_PER_BLOCK = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [15:0]           req_tdata,  // block_index
   input  logic [2:0]            req_tuser,  // operation, bad_block
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [39:0]           rsp_tdata,  // page_address, empty_count, reserved_count
   input  logic                  rsp_tuser,  // error
   input  logic                  csr_we,
   input  cfg_index_type         csr_index,
   input  logic [CFG_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [ADDR_W-1:0]  page_address;
      logic               error;
      logic [COUNT_W-1:0] empty_count;
      logic [COUNT_W-1:0] reserved_count;
   } page_result_type;

   block_type    empty_ring    [NUM_BLOCKS];
   block_type    reserved_ring [NUM_BLOCKS];
   int unsigned  empty_head;
   int unsigned  empty_tail;
   int unsigned  empty_used;
   int unsigned  reserved_tail;
   int unsigned  reserved_used;
   block_type    open_block;
   bit           open_valid;
   int unsigned  page_offset;
   bit           relocate_mode;
   int unsigned  reserved_target;

   page_result_type expected_pages [$];
   page_result_type got;
   page_result_type want;
   int              fails;

   function automatic void push_empty_block(block_type blk);
      if (empty_used < NUM_BLOCKS) begin
         empty_ring[empty_tail] = blk;
         empty_tail = (empty_tail + 1) % NUM_BLOCKS;
         empty_used++;
      end
   endfunction

   function automatic void push_reserved_block(block_type blk);
      if (reserved_used < NUM_BLOCKS) begin
         reserved_ring[reserved_tail] = blk;
         reserved_tail = (reserved_tail + 1) % NUM_BLOCKS;
         reserved_used++;
      end
   endfunction

   function automatic block_type take_empty_block();
      block_type blk;
      blk = empty_ring[empty_head];
      empty_head = (empty_head + 1) % NUM_BLOCKS;
      empty_used--;
      return blk;
   endfunction

   function automatic page_result_type next_page_result(op_type op, block_type blk, logic bad);
      page_result_type res;
      int unsigned     addr;
      logic            err;
      addr = 0;
      err = 1'b0;
      case (op)
         OP_REGISTER: begin
            if (!bad) begin
               if (reserved_used < reserved_target) push_reserved_block(blk);
               else push_empty_block(blk);
            end
         end
         OP_ALLOC: begin
            if (!open_valid || page_offset >= PAGES_PER_BLOCK) begin
               if (empty_used == 0) begin
                  err = 1'b1;
               end else begin
                  open_block = take_empty_block();
                  open_valid = 1'b1;
                  page_offset = 1;
                  addr = open_block * PAGES_PER_BLOCK;
               end
            end else if (relocate_mode && empty_used != 0) begin
               // relocate to a fresh block, offset carried over
               open_block = take_empty_block();
               addr = open_block * PAGES_PER_BLOCK + page_offset;
               page_offset++;
            end else begin
               addr = open_block * PAGES_PER_BLOCK + page_offset;
               page_offset++;
            end
         end
         OP_FREE_EMPTY: push_empty_block(blk);
         default: push_reserved_block(blk);
      endcase
      res.page_address   = addr[ADDR_W-1:0];
      res.error          = err;
      res.empty_count    = COUNT_W'(empty_used);
      res.reserved_count = COUNT_W'(reserved_used);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         empty_head = 0;
         empty_tail = 0;
         empty_used = 0;
         reserved_tail = 0;
         reserved_used = 0;
         open_block = '0;
         open_valid = 1'b0;
         page_offset = 0;
         relocate_mode = 1'b0;
         reserved_target = RESERVED_TARGET_RESET;
         expected_pages.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CFG_RELOCATE_MODE: relocate_mode = csr_wdata[0];
               CFG_RESERVED_TARGET: reserved_target = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.page_address   = rsp_tdata[ADDR_W-1:0];
            got.error          = rsp_tuser;
            got.empty_count    = rsp_tdata[ADDR_W +: COUNT_W];
            got.reserved_count = rsp_tdata[ADDR_W+COUNT_W +: COUNT_W];
            if (expected_pages.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected response: addr %0d err %0d empty %0d rsv %0d",
                           got.page_address, got.error, got.empty_count,
                           got.reserved_count);
            end else begin
               want = expected_pages.pop_front();
               if (got.page_address !== want.page_address || got.error !== want.error ||
                   got.empty_count !== want.empty_count ||
                   got.reserved_count !== want.reserved_count) begin
                  fails++;
                  if (fails <= 10)
                     $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              want.page_address, want.error, want.empty_count,
                              want.reserved_count, got.page_address, got.error,
                              got.empty_count, got.reserved_count);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_pages.push_back(next_page_result(req_tuser[1:0], req_tdata[BLOCK_W-1:0],
                                                      req_tuser[2]));
      end
      mismatch_count <= fails;
      pending_count <= expected_pages.size();
   end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import fpa_pkg::*;

   localparam int CLOCK_PERIOD = 20;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;  // block_index
   logic [2:0]            req_tuser  = '0;  // operation, bad_block
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;        // page_address, empty_count, reserved_count
   logic                  rsp_tuser;        // error
   logic                  csr_we     = 1'b0;
   cfg_index_type         csr_index  = CFG_RELOCATE_MODE;
   logic [CFG_DATA_W-1:0] csr_wdata  = '0;

   int mismatch_count;
   int pending_count;
   bit calm_mode = 1'b0;
   int ready_hold = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   flash_page_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   fpa_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (calm_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         rsp_tready <= 1'b0;
         ready_hold = ready_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         ready_hold = pick_gap();
      end
   end

   task automatic send_request(op_type op, block_type blk, logic bad);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(16 - BLOCK_W){1'b0}}, blk};
      req_tuser <= {bad, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(logic gc, logic [CFG_DATA_W-1:0] target);
      csr_we <= 1'b1;
      csr_index <= CFG_RELOCATE_MODE;
      csr_wdata <= {{(CFG_DATA_W - 1){1'b0}}, gc};
      @(posedge clock);
      csr_index <= CFG_RESERVED_TARGET;
      csr_wdata <= target;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic block_type any_block();
      return block_type'($urandom_range(0, 1023));
   endfunction

   task automatic random_phase(int count, logic gc, logic [CFG_DATA_W-1:0] target);
      int r;
      drain();
      set_config(gc, target);
      calm_mode = ($urandom_range(0, 3) == 0);
      // init style registrations first, then a random mix
      repeat (10) send_request(OP_REGISTER, any_block(), $urandom_range(0, 3) == 0);
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 25) send_request(OP_REGISTER, any_block(), $urandom_range(0, 2) == 0);
         else if (r < 65) send_request(OP_ALLOC, any_block(), 1'($urandom_range(0, 1)));
         else if (r < 85) send_request(OP_FREE_EMPTY, any_block(), 1'($urandom_range(0, 1)));
         else send_request(OP_FREE_RESERVED, any_block(), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: one reserved block
      send_request(OP_ALLOC, 10'd0, 1'b0);
      send_request(OP_REGISTER, 10'd0, 1'b0);
      send_request(OP_REGISTER, 10'h3FF, 1'b1);
      send_request(OP_REGISTER, 10'h3FF, 1'b0);
      send_request(OP_REGISTER, 10'h2AA, 1'b0);
      send_request(OP_ALLOC, 10'h3FF, 1'b1);
      send_request(OP_ALLOC, 10'd0, 1'b0);
      send_request(OP_FREE_EMPTY, 10'h155, 1'b1);
      send_request(OP_FREE_RESERVED, 10'h3FF, 1'b0);
      drain();
      // relocation mode, then running out of empty blocks
      set_config(1'b1, 5'd0);
      send_request(OP_ALLOC, 10'd0, 1'b0);
      send_request(OP_ALLOC, 10'd0, 1'b0);
      send_request(OP_ALLOC, 10'd0, 1'b0);
      send_request(OP_REGISTER, 10'd7, 1'b0);
      send_request(OP_ALLOC, 10'd0, 1'b0);
      send_request(OP_ALLOC, 10'd0, 1'b0);
      drain();
      set_config(1'b0, 5'd16);
      send_request(OP_REGISTER, 10'd1, 1'b0);
      send_request(OP_REGISTER, 10'h200, 1'b0);
      send_request(OP_REGISTER, 10'h3FE, 1'b0);
      send_request(OP_FREE_EMPTY, 10'd0, 1'b0);
      send_request(OP_ALLOC, 10'd0, 1'b0);

      // run the open block to its end, open the next, then hit error with a full block
      drain();
      set_config(1'b0, 5'd0);
      calm_mode = 1'b1;
      repeat (510) send_request(OP_ALLOC, any_block(), 1'($urandom_range(0, 1)));

      random_phase(30, 1'b1, 5'd16);
      random_phase(30, 1'b0, 5'd7);
      random_phase(30, 1'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(0, 16)));

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("flash_page_allocator verification clean");
      end else begin
         $display("flash_page_allocator verification failed");
      end
      $finish;
   end

   initial begin
      #(40_000_000);
      $display("flash_page_allocator verification failed");
      $finish;
   end

endmodule
